// ===== rtl/i2c_register_bridge_core_macros.svh =====
`ifndef I2C_REGISTER_BRIDGE_CORE_MACROS_SVH
`define I2C_REGISTER_BRIDGE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define I2CRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2crb_pkg.sv =====
package i2crb_pkg;

  // Reset value of the register presence map.
  localparam logic [63:0] MAP_RESET = 64'h003F_FFFF_3F77_7E7D;

  // Depth of the queue between front and back; must be a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation classes produced by the front part.
  typedef enum logic [2:0] {
    OP_WRITE_START,
    OP_WRITE_BYTE,
    OP_READ_START,
    OP_READ_MORE,
    OP_STOP,
    OP_TICK,
    OP_NOP
  } op_e;

  // One classified word as it travels through the queue.
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } op_t;

  // Push side of the queue.
  typedef struct packed {
    logic valid;
    op_t  item;
  } push_t;

  // Queue status seen by both parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/i2crb_in_if.sv =====
interface i2crb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

// ===== rtl/i2crb_out_if.sv =====
interface i2crb_out_if;
  logic       valid;
  logic       ready;
  logic       ack;
  logic       has_data;
  logic [7:0] read_data;

  modport source (output valid, output ack, output has_data, output read_data, input ready);
  modport sink (input valid, input ack, input has_data, input read_data, output ready);
endinterface

// ===== rtl/i2crb_fifo.sv =====
module i2crb_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  i2crb_pkg::push_t  push_i,
  input  logic              pop_i,
  output i2crb_pkg::op_t    head_o,
  output i2crb_pkg::q_stat_t stat_o
);

  localparam int unsigned Depth = i2crb_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = i2crb_pkg::QPTR_W;
  localparam int unsigned CntW  = i2crb_pkg::QCNT_W;

  i2crb_pkg::op_t slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  // Status and gated handshakes.
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i.valid && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = slot_q[rd_ptr_q];

  // Pointers wrap naturally since the depth is a power of two.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

// ===== rtl/i2crb_front.sv =====
module i2crb_front (
  i2crb_in_if.sink            in_i,
  input  i2crb_pkg::q_stat_t  q_stat_i,
  output i2crb_pkg::push_t    q_push_o
);

  // Bus event codes on the input channel.
  localparam logic [2:0] EvWriteStart = 3'd0;
  localparam logic [2:0] EvWriteByte  = 3'd1;
  localparam logic [2:0] EvReadStart  = 3'd2;
  localparam logic [2:0] EvReadMore   = 3'd3;
  localparam logic [2:0] EvStop       = 3'd4;
  localparam logic [2:0] EvTick       = 3'd5;

  i2crb_pkg::op_e op;

  // Classify the bus event; undefined codes become no-operation words.
  always_comb begin
    unique case (in_i.cmd)
      EvWriteStart: op = i2crb_pkg::OP_WRITE_START;
      EvWriteByte:  op = i2crb_pkg::OP_WRITE_BYTE;
      EvReadStart:  op = i2crb_pkg::OP_READ_START;
      EvReadMore:   op = i2crb_pkg::OP_READ_MORE;
      EvStop:       op = i2crb_pkg::OP_STOP;
      EvTick:       op = i2crb_pkg::OP_TICK;
      default:      op = i2crb_pkg::OP_NOP;
    endcase
  end

  // A word is taken whenever the queue has room.
  assign in_i.ready          = !q_stat_i.full;
  assign q_push_o.valid      = in_i.valid && !q_stat_i.full;
  assign q_push_o.item.op    = op;
  assign q_push_o.item.data  = in_i.data_byte;

endmodule

// ===== rtl/i2crb_back.sv =====
module i2crb_back #(
  parameter int unsigned NUM_REGS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [63:0]        cfg_wdata_i,
  input  i2crb_pkg::op_t     head_i,
  input  i2crb_pkg::q_stat_t q_stat_i,
  output logic               pop_o,
  i2crb_out_if.source        out_o
);

  localparam int unsigned AddrW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // Command byte codes.
  localparam logic [7:0] CbReadReg   = 8'd1;
  localparam logic [7:0] CbWriteReg  = 8'd2;
  localparam logic [7:0] CbLatchTmr  = 8'd3;
  localparam logic [7:0] CbLoadTmr   = 8'd4;
  localparam logic [7:0] CbClearTmr  = 8'd5;
  localparam logic [7:0] CbSoftReset = 8'd6;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMD,
    PH_RADDR,
    PH_WADDR,
    PH_WDATA,
    PH_TLO,
    PH_THI,
    PH_DONE
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [63:0]     map_q, map_d;
  logic [15:0]     timer_q, timer_d;
  logic [7:0]      hold0_q, hold0_d;
  logic [7:0]      hold1_q, hold1_d;
  logic            hold0_mem_q, hold0_mem_d;
  logic [7:0]      paddr_q, paddr_d;
  logic [1:0]      rpos_q, rpos_d;
  logic [NUM_REGS-1:0] vld_q, vld_d;
  logic            rd_ok_q, rd_ok_d;
  logic            out_valid_q, out_valid_d;
  logic            ack_q, ack_d;
  logic            has_q, has_d;
  logic [7:0]      rdat_q, rdat_d;

  logic [7:0]      mem_q [NUM_REGS];
  logic [7:0]      mem_rdata_q;
  logic            mem_we;
  logic            mem_re;
  logic [7:0]      hold0_eff;
  i2crb_pkg::op_t  item;

  // Address is backed by a register when in range and present in the map.
  function automatic logic is_mapped(input logic [7:0] a, input logic [63:0] map);
    return ({1'b0, a} < 9'(NUM_REGS)) && (a[7:6] == 2'b00) && map[a[5:0]];
  endfunction

  // Take a word when the output register is free or being emptied.
  assign pop_o = !q_stat_i.empty && (!out_valid_q || out_o.ready);
  assign item  = head_i;

  // Holding byte 0 may still sit in the memory read register.
  assign hold0_eff = hold0_mem_q ? (rd_ok_q ? mem_rdata_q : 8'd0) : hold0_q;

  // Execute one word.
  always_comb begin
    phase_d     = phase_q;
    map_d       = cfg_we_i ? cfg_wdata_i : map_q;
    timer_d     = timer_q;
    hold0_d     = hold0_q;
    hold1_d     = hold1_q;
    hold0_mem_d = hold0_mem_q;
    paddr_d     = paddr_q;
    rpos_d      = rpos_q;
    vld_d       = vld_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q && !out_o.ready;
    ack_d       = ack_q;
    has_d       = has_q;
    rdat_d      = rdat_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    if (pop_o) begin
      out_valid_d = 1'b1;
      ack_d       = 1'b0;
      has_d       = 1'b0;
      rdat_d      = 8'd0;
      unique case (item.op)
        i2crb_pkg::OP_WRITE_START: begin
          phase_d = PH_CMD;
          rpos_d  = 2'd0;
        end
        i2crb_pkg::OP_WRITE_BYTE: begin
          unique case (phase_q)
            PH_CMD: begin
              ack_d = 1'b1;
              unique case (item.data)
                CbReadReg:  phase_d = PH_RADDR;
                CbWriteReg: phase_d = PH_WADDR;
                CbLatchTmr: begin
                  hold0_d     = timer_q[7:0];
                  hold1_d     = timer_q[15:8];
                  hold0_mem_d = 1'b0;
                  phase_d     = PH_DONE;
                end
                CbLoadTmr:  phase_d = PH_TLO;
                CbClearTmr: begin
                  timer_d = 16'd0;
                  phase_d = PH_DONE;
                end
                CbSoftReset: begin
                  vld_d       = '0;
                  timer_d     = 16'd0;
                  hold0_d     = 8'd0;
                  hold1_d     = 8'd0;
                  hold0_mem_d = 1'b0;
                  phase_d     = PH_IDLE;
                  paddr_d     = 8'd0;
                  rpos_d      = 2'd0;
                end
                default: begin
                  ack_d   = 1'b0;
                  phase_d = PH_DONE;
                end
              endcase
            end
            PH_RADDR: begin
              mem_re      = 1'b1;
              rd_ok_d     = is_mapped(item.data, map_q) && vld_q[item.data[AddrW-1:0]];
              hold0_mem_d = 1'b1;
              phase_d     = PH_DONE;
              ack_d       = 1'b1;
            end
            PH_WADDR: begin
              paddr_d = item.data;
              phase_d = PH_WDATA;
              ack_d   = 1'b1;
            end
            PH_WDATA: begin
              if (is_mapped(paddr_q, map_q)) begin
                mem_we                      = 1'b1;
                vld_d[paddr_q[AddrW-1:0]]   = 1'b1;
              end
              phase_d = PH_DONE;
              ack_d   = 1'b1;
            end
            PH_TLO: begin
              hold0_d     = item.data;
              hold0_mem_d = 1'b0;
              phase_d     = PH_THI;
              ack_d       = 1'b1;
            end
            PH_THI: begin
              hold1_d = item.data;
              timer_d = {item.data, hold0_eff};
              phase_d = PH_DONE;
              ack_d   = 1'b1;
            end
            default: begin
              ack_d = 1'b0;
            end
          endcase
        end
        i2crb_pkg::OP_READ_START: begin
          phase_d = PH_IDLE;
          has_d   = 1'b1;
          rdat_d  = hold0_eff;
          rpos_d  = 2'd1;
        end
        i2crb_pkg::OP_READ_MORE: begin
          if (rpos_q == 2'd1) begin
            has_d  = 1'b1;
            rdat_d = hold1_q;
            rpos_d = 2'd2;
          end
        end
        i2crb_pkg::OP_STOP: begin
          phase_d = PH_IDLE;
          rpos_d  = 2'd0;
        end
        i2crb_pkg::OP_TICK: begin
          timer_d = timer_q + 16'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      map_q       <= i2crb_pkg::MAP_RESET;
      timer_q     <= 16'd0;
      hold0_q     <= 8'd0;
      hold1_q     <= 8'd0;
      hold0_mem_q <= 1'b0;
      paddr_q     <= 8'd0;
      rpos_q      <= 2'd0;
      vld_q       <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ack_q       <= 1'b0;
      has_q       <= 1'b0;
      rdat_q      <= 8'd0;
    end else begin
      phase_q     <= phase_d;
      map_q       <= map_d;
      timer_q     <= timer_d;
      hold0_q     <= hold0_d;
      hold1_q     <= hold1_d;
      hold0_mem_q <= hold0_mem_d;
      paddr_q     <= paddr_d;
      rpos_q      <= rpos_d;
      vld_q       <= vld_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
      ack_q       <= ack_d;
      has_q       <= has_d;
      rdat_q      <= rdat_d;
    end
  end

  // Register file with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[paddr_q[AddrW-1:0]] <= item.data;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[item.data[AddrW-1:0]];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.ack       = ack_q;
  assign out_o.has_data  = has_q;
  assign out_o.read_data = rdat_q;

endmodule

// ===== rtl/i2c_register_bridge_core.sv =====
// An accepted word passes through the queue and then the output register before it is presented as a result.
// Throughput: one word per cycle while the receiver takes results, set by the execute step in the back part.
// A two-entry queue lets input words be taken while a result waits at the output.
// Reset: asynchronous, active low; all state clears at once, the register file through
// per-entry valid bits, so no clearing pass is needed. Soft reset keeps the presence map.
`include "i2c_register_bridge_core_macros.svh"

module i2c_register_bridge_core #(
  parameter int unsigned NUM_REGS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  i2crb_in_if.sink    in_i,
  i2crb_out_if.source out_o
);

  i2crb_pkg::push_t   q_push;
  i2crb_pkg::q_stat_t q_stat;
  i2crb_pkg::op_t     q_head;
  logic               q_pop;
  logic               q_drain;

  // Front part: accept and classify bus words.
  i2crb_front u_front (
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push)
  );

  // Queue between the two parts.
  i2crb_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  // Back part: execute commands and drive results.
  i2crb_back #(
    .NUM_REGS (NUM_REGS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (q_head),
    .q_stat_i    (q_stat),
    .pop_o       (q_pop),
    .out_o       (out_o)
  );

  // A queued word meets a free output slot.
  assign q_drain = !q_stat.empty && (!out_o.valid || out_o.ready);

  // The back part never takes from an empty queue.
  `I2CRB_ASSERT_NOW(a_pop_not_empty, clk_i, rst_ni, q_pop, !q_stat.empty, "pop from empty queue")

  // A queued word with a free output slot shows up as a result next cycle.
  `I2CRB_ASSERT_NEXT(a_queue_drains, clk_i, rst_ni, q_drain, out_o.valid, "queued word stuck")

  // A result never both acknowledges a byte and carries read data.
  `I2CRB_ASSERT_NOW(a_ack_xor_data, clk_i, rst_ni, out_o.ack, !out_o.has_data, "ack with data")

endmodule

// ===== tb/tb_i2c_register_bridge_core.sv =====
`timescale 1ns / 1ps

module tb_i2c_register_bridge_core;

  localparam int unsigned NUM_REGS = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_REPORTS = 10;

  // Bus codes not covered by the package enum.
  localparam logic [2:0] CMD_UNDEFINED = 3'd7;

  // Command bytes carried in the first byte of a write transaction.
  localparam logic [7:0] CB_UNKNOWN     = 8'h00;
  localparam logic [7:0] CB_READ_REG    = 8'h01;
  localparam logic [7:0] CB_WRITE_REG   = 8'h02;
  localparam logic [7:0] CB_LATCH_TIMER = 8'h03;
  localparam logic [7:0] CB_LOAD_TIMER  = 8'h04;
  localparam logic [7:0] CB_CLEAR_TIMER = 8'h05;
  localparam logic [7:0] CB_SOFT_RESET  = 8'h06;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMD,
    PH_RADDR,
    PH_WADDR,
    PH_WDATA,
    PH_TLO,
    PH_THI,
    PH_DONE
  } bridge_phase_e;

  typedef struct packed {
    logic       ack;
    logic       has_data;
    logic [7:0] read_data;
  } bridge_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [63:0] cfg_wdata_i;

  i2crb_in_if  bridge_in ();
  i2crb_out_if bridge_out ();

  i2c_register_bridge_core #(
    .NUM_REGS(NUM_REGS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (bridge_in),
    .out_o      (bridge_out)
  );

  // Mirror of the bridge state.
  logic [63:0]   model_map;
  logic [7:0]    model_regs [NUM_REGS];
  logic [15:0]   model_timer;
  logic [7:0]    model_hold [2];
  bridge_phase_e model_phase;
  logic [7:0]    model_pending_addr;
  logic [1:0]    model_read_pos;

  bridge_result_t expected_results[$];
  bridge_result_t oldest_result;

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned words_sent;
  int unsigned burst_left;
  bit          sender_steady;
  bit          rx_always_ready;
  bit          rx_state;
  int unsigned rx_count;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Clears everything a soft reset clears; the presence map is kept.
  function automatic void clear_bridge_state();
    for (int i = 0; i < NUM_REGS; i++) begin
      model_regs[i] = 8'h00;
    end
    model_timer = 16'h0000;
    model_hold[0] = 8'h00;
    model_hold[1] = 8'h00;
    model_phase = PH_IDLE;
    model_pending_addr = 8'h00;
    model_read_pos = 2'd0;
  endfunction

  function automatic logic reg_present(input logic [7:0] addr);
    return (addr < NUM_REGS) && (addr < 8'd64) && model_map[addr[5:0]];
  endfunction

  // Advances the write transaction by one received byte; returns the acknowledge.
  function automatic logic take_write_byte(input logic [7:0] data);
    logic acked;
    acked = 1'b1;
    case (model_phase)
      PH_CMD: begin
        case (data)
          CB_READ_REG:  model_phase = PH_RADDR;
          CB_WRITE_REG: model_phase = PH_WADDR;
          CB_LATCH_TIMER: begin
            model_hold[0] = model_timer[7:0];
            model_hold[1] = model_timer[15:8];
            model_phase = PH_DONE;
          end
          CB_LOAD_TIMER: model_phase = PH_TLO;
          CB_CLEAR_TIMER: begin
            model_timer = 16'h0000;
            model_phase = PH_DONE;
          end
          CB_SOFT_RESET: clear_bridge_state();
          default: begin
            model_phase = PH_DONE;
            acked = 1'b0;
          end
        endcase
      end
      PH_RADDR: begin
        model_hold[0] = reg_present(data) ? model_regs[data[5:0]] : 8'h00;
        model_phase = PH_DONE;
      end
      PH_WADDR: begin
        model_pending_addr = data;
        model_phase = PH_WDATA;
      end
      PH_WDATA: begin
        if (reg_present(model_pending_addr)) begin
          model_regs[model_pending_addr[5:0]] = data;
        end
        model_phase = PH_DONE;
      end
      PH_TLO: begin
        model_hold[0] = data;
        model_phase = PH_THI;
      end
      PH_THI: begin
        model_hold[1] = data;
        model_timer = {model_hold[1], model_hold[0]};
        model_phase = PH_DONE;
      end
      default: acked = 1'b0;
    endcase
    return acked;
  endfunction

  // Computes the result of one bus word and updates the mirrored state.
  function automatic bridge_result_t predict_bus_word(input logic [2:0] cmd,
                                                      input logic [7:0] data);
    bridge_result_t res;
    res = '0;
    case (cmd)
      i2crb_pkg::OP_WRITE_START: begin
        model_phase = PH_CMD;
        model_read_pos = 2'd0;
      end
      i2crb_pkg::OP_WRITE_BYTE: res.ack = take_write_byte(data);
      i2crb_pkg::OP_READ_START: begin
        model_phase = PH_IDLE;
        res.has_data = 1'b1;
        res.read_data = model_hold[0];
        model_read_pos = 2'd1;
      end
      i2crb_pkg::OP_READ_MORE: begin
        if (model_read_pos == 2'd1) begin
          res.has_data = 1'b1;
          res.read_data = model_hold[1];
          model_read_pos = 2'd2;
        end
      end
      i2crb_pkg::OP_STOP: begin
        model_phase = PH_IDLE;
        model_read_pos = 2'd0;
      end
      i2crb_pkg::OP_TICK: model_timer = model_timer + 16'd1;
      default: ;
    endcase
    return res;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        bridge_in.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Presents one word and returns at the edge that accepts it; valid stays high.
  task automatic send_word(input logic [2:0] cmd, input logic [7:0] data);
    pace_sender();
    bridge_in.valid <= 1'b1;
    bridge_in.cmd <= cmd;
    bridge_in.data_byte <= data;
    @(posedge clk_i);
    while (!bridge_in.ready) @(posedge clk_i);
    expected_results.push_back(predict_bus_word(cmd, data));
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] data);
    send_word(i2crb_pkg::OP_WRITE_BYTE, data);
  endtask

  // Holds the sender until every expected word has come back, then lets the pipe settle.
  task automatic drain_results();
    bridge_in.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_present_map(input logic [63:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    model_map = value;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_address();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 8'($urandom_range(0, 15));
    if (sel < 9) return 8'($urandom_range(0, 63));
    return 8'($urandom_range(0, 255));
  endfunction

  // Register write, repeated start read, unmapped address, byte after completion.
  task automatic test_register_access();
    send_word(i2crb_pkg::OP_WRITE_START, 8'h00);
    send_byte(CB_WRITE_REG);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_word(i2crb_pkg::OP_WRITE_START, 8'hFF);
    send_byte(CB_READ_REG);
    send_byte(8'h00);
    send_word(i2crb_pkg::OP_READ_START, 8'h00);
    send_word(i2crb_pkg::OP_READ_MORE, 8'h00);
    send_word(i2crb_pkg::OP_READ_MORE, 8'h00);
    send_word(i2crb_pkg::OP_WRITE_START, 8'h00);
    send_byte(CB_WRITE_REG);
    send_byte(8'h01);
    send_byte(8'h55);
    send_byte(8'hAA);
  endtask

  // Timer load with wrap on tick, latch, clear, and an aborted load.
  task automatic test_timer_commands();
    send_word(i2crb_pkg::OP_WRITE_START, 8'h00);
    send_byte(CB_LOAD_TIMER);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_word(i2crb_pkg::OP_TICK, 8'hFF);
    send_word(i2crb_pkg::OP_WRITE_START, 8'h00);
    send_byte(CB_LATCH_TIMER);
    send_word(i2crb_pkg::OP_READ_START, 8'h00);
    send_word(i2crb_pkg::OP_READ_MORE, 8'h00);
    send_word(i2crb_pkg::OP_WRITE_START, 8'h00);
    send_byte(CB_LOAD_TIMER);
    send_byte(8'h12);
    send_word(i2crb_pkg::OP_STOP, 8'h00);
    send_word(i2crb_pkg::OP_READ_START, 8'h00);
    send_word(i2crb_pkg::OP_WRITE_START, 8'h00);
    send_byte(CB_CLEAR_TIMER);
  endtask

  // Unknown command byte, byte with no start, undefined codes, read more with no start.
  task automatic test_protocol_corners();
    send_word(i2crb_pkg::OP_WRITE_START, 8'h00);
    send_byte(CB_UNKNOWN);
    send_byte(8'h2A);
    send_word(i2crb_pkg::OP_STOP, 8'h00);
    send_byte(CB_WRITE_REG);
    send_word(i2crb_pkg::OP_NOP, 8'hFF);
    send_word(CMD_UNDEFINED, 8'h00);
    send_word(i2crb_pkg::OP_READ_MORE, 8'h00);
  endtask

  task automatic test_soft_reset();
    send_word(i2crb_pkg::OP_WRITE_START, 8'h00);
    send_byte(CB_SOFT_RESET);
    send_byte(8'h00);
    send_word(i2crb_pkg::OP_READ_START, 8'h00);
  endtask

  // One random transaction; most are well formed, the rest broken or plain noise.
  task automatic send_random_transaction();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 22) begin
      send_word(i2crb_pkg::OP_WRITE_START, 8'($urandom));
      send_byte(CB_WRITE_REG);
      send_byte(pick_address());
      send_byte(8'($urandom));
      if ($urandom_range(0, 3) != 0) send_word(i2crb_pkg::OP_STOP, 8'($urandom));
    end else if (kind < 44) begin
      send_word(i2crb_pkg::OP_WRITE_START, 8'($urandom));
      send_byte(CB_READ_REG);
      send_byte(pick_address());
      if ($urandom_range(0, 1) != 0) send_word(i2crb_pkg::OP_STOP, 8'($urandom));
      send_word(i2crb_pkg::OP_READ_START, 8'($urandom));
      if ($urandom_range(0, 9) < 7) send_word(i2crb_pkg::OP_READ_MORE, 8'($urandom));
      if ($urandom_range(0, 9) == 0) send_word(i2crb_pkg::OP_READ_MORE, 8'($urandom));
      send_word(i2crb_pkg::OP_STOP, 8'($urandom));
    end else if (kind < 52) begin
      send_word(i2crb_pkg::OP_WRITE_START, 8'($urandom));
      send_byte(CB_LATCH_TIMER);
      if ($urandom_range(0, 1) != 0) send_word(i2crb_pkg::OP_STOP, 8'($urandom));
      send_word(i2crb_pkg::OP_READ_START, 8'($urandom));
      send_word(i2crb_pkg::OP_READ_MORE, 8'($urandom));
      send_word(i2crb_pkg::OP_STOP, 8'($urandom));
    end else if (kind < 60) begin
      send_word(i2crb_pkg::OP_WRITE_START, 8'($urandom));
      send_byte(CB_LOAD_TIMER);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      send_word(i2crb_pkg::OP_STOP, 8'($urandom));
    end else if (kind < 64) begin
      send_word(i2crb_pkg::OP_WRITE_START, 8'($urandom));
      send_byte(CB_CLEAR_TIMER);
      send_word(i2crb_pkg::OP_STOP, 8'($urandom));
    end else if (kind < 74) begin
      n = $urandom_range(1, 6);
      repeat (n) send_word(i2crb_pkg::OP_TICK, 8'($urandom));
    end else if (kind < 75) begin
      send_word(i2crb_pkg::OP_WRITE_START, 8'($urandom));
      send_byte(CB_SOFT_RESET);
    end else if (kind < 87) begin
      // Broken transaction: any command byte, a few bytes, then abort or restart.
      send_word(i2crb_pkg::OP_WRITE_START, 8'($urandom));
      send_byte(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom));
      n = $urandom_range(0, 3);
      repeat (n) send_byte(8'($urandom));
      if ($urandom_range(0, 1) != 0) send_word(i2crb_pkg::OP_STOP, 8'($urandom));
      else send_word(i2crb_pkg::OP_READ_START, 8'($urandom));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_word(3'($urandom_range(0, 7)), 8'($urandom));
    end
  endtask

  // Random traffic until the given number of words has been accepted.
  task automatic test_random_traffic(input int unsigned word_count);
    int unsigned target;
    int unsigned next_switch;
    target = words_sent + word_count;
    next_switch = words_sent;
    while (words_sent < target) begin
      if (words_sent >= next_switch) begin
        sender_steady = ($urandom_range(0, 3) == 0);
        rx_always_ready = ($urandom_range(0, 3) == 0);
        next_switch = words_sent + $urandom_range(60, 200);
      end
      send_random_transaction();
    end
  endtask

  // Random traffic under each presence map, the extremes among them.
  task automatic test_map_settings();
    test_random_traffic(370);
    write_present_map({64{1'b1}});
    test_random_traffic(370);
    write_present_map(64'h0);
    test_random_traffic(370);
    write_present_map({$urandom, $urandom});
    test_random_traffic(370);
    write_present_map(i2crb_pkg::MAP_RESET);
    test_random_traffic(370);
  endtask

  // Result checker, cycle limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_ni && bridge_out.valid && bridge_out.ready) begin
      if (expected_results.size() == 0) begin
        note_error($sformatf("unexpected word ack=%0b has_data=%0b read_data=%02h",
                             bridge_out.ack, bridge_out.has_data, bridge_out.read_data));
      end else begin
        oldest_result = expected_results.pop_front();
        if (bridge_out.ack !== oldest_result.ack ||
            bridge_out.has_data !== oldest_result.has_data ||
            bridge_out.read_data !== oldest_result.read_data) begin
          note_error($sformatf({"mismatch: expected ack=%0b has_data=%0b read_data=%02h, ",
                                "got ack=%0b has_data=%0b read_data=%02h"},
                               oldest_result.ack, oldest_result.has_data,
                               oldest_result.read_data, bridge_out.ack,
                               bridge_out.has_data, bridge_out.read_data));
        end
      end
    end
  end

  // Receiver stalls: alternating ready and stall runs, now and then a long stall.
  always @(posedge clk_i) begin
    if (rx_always_ready) begin
      bridge_out.ready <= 1'b1;
    end else if (rx_count == 0) begin
      rx_state = !rx_state;
      if (rx_state) begin
        rx_count = $urandom_range(1, 10);
      end else begin
        rx_count = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 4);
      end
      bridge_out.ready <= rx_state;
    end else begin
      rx_count--;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 64'h0;
    bridge_in.valid = 1'b0;
    bridge_in.cmd = i2crb_pkg::OP_NOP;
    bridge_in.data_byte = 8'h00;
    bridge_out.ready = 1'b0;
    error_count = 0;
    cycle_count = 0;
    words_sent = 0;
    burst_left = 0;
    sender_steady = 1'b0;
    rx_always_ready = 1'b0;
    rx_state = 1'b0;
    rx_count = 0;
    model_map = i2crb_pkg::MAP_RESET;
    clear_bridge_state();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_timer_commands();
    test_protocol_corners();
    test_soft_reset();
    test_map_settings();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      note_error("expected words left over at the end");
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
